// ===== rtl/core/lzfb_pkg.sv =====
// Package for the LZ77 flag-byte decompressor: widths, result codes,
// result struct and the sequencer state type. No dependencies.
package lzfb_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int COUNT_BITS   = 24;
    localparam int TOTAL_W      = 24;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;
    localparam int DIST_W       = ADDR_W + 1;
    localparam int BITS_W       = 4;

    localparam logic [LEN_W-1:0]  LEN_BIAS   = LEN_W'(3);
    localparam logic [BITS_W-1:0] FLAG_COUNT = BITS_W'(8);

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  data;
        logic [TOTAL_W-1:0] total;
        logic               run_last;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LIT  = 5'b00010,
        ST_COPY = 5'b00100,
        ST_ERR  = 5'b01000,
        ST_END  = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/lzfb_if.sv =====
// Valid/ready channel interfaces for compressed input and result output.
// Depends on lzfb_pkg.
interface lzfb_in_if;
    logic                       valid;
    logic                       ready;
    logic [lzfb_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzfb_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   result_kind;
    logic [lzfb_pkg::BYTE_W-1:0]  out_byte;
    logic [lzfb_pkg::TOTAL_W-1:0] total_count;
    logic                         run_last;

    modport source (output valid, output result_kind, output out_byte,
                    output total_count, output run_last, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input total_count, input run_last, output ready);
endinterface

// ===== rtl/core/lzfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module lzfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lzfb_engine.sv =====
// Token parser and copy sequencer around the history RAM.
// Depends on lzfb_pkg and lzfb_ram.
module lzfb_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [lzfb_pkg::BYTE_W-1:0] in_byte,
    input  logic                        in_last,
    output logic                        in_ready,
    input  logic                        can_emit,
    output lzfb_pkg::result_t           res
);
    import lzfb_pkg::*;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     wp_reg, wp_next;
    logic [COUNT_BITS-1:0] prod_reg, prod_next, prod_inc;
    logic [BYTE_W-1:0]     flag_reg, flag_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic                  pend_reg, pend_next;
    logic [BYTE_W-1:0]     high_reg, high_next;
    logic                  err_reg, err_next;
    logic                  last_reg, last_next;
    logic [BYTE_W-1:0]     lit_reg, lit_next;
    logic [ADDR_W-1:0]     src_reg, src_next;
    logic [LEN_W-1:0]      left_reg, left_next;
    logic                  rdp_reg, rdp_next;
    logic                  fwd_reg, fwd_next;
    logic [BYTE_W-1:0]     fwdd_reg, fwdd_next;

    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]     copy_byte;
    logic [DIST_W-1:0]     ref_dist;
    logic [LEN_W-1:0]      len;
    logic                  clear;
    logic                  emit_now;
    logic                  issue;

    lzfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign ref_dist  = {1'b0, high_reg[3:0], in_byte} + DIST_W'(1);
    assign len       = LEN_W'(high_reg[7:4]) + LEN_BIAS;
    assign prod_inc  = (prod_reg == {COUNT_BITS{1'b1}}) ? prod_reg
                                                         : prod_reg + COUNT_BITS'(1);
    assign copy_byte = fwd_reg ? fwdd_reg : ram_rdata;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        prod_next  = prod_reg;
        flag_next  = flag_reg;
        bits_next  = bits_reg;
        pend_next  = pend_reg;
        high_next  = high_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        lit_next   = lit_reg;
        src_next   = src_reg;
        left_next  = left_reg;
        rdp_next   = rdp_reg;
        fwd_next   = fwd_reg;
        fwdd_next  = fwdd_reg;
        ram_we     = 1'b0;
        ram_wdata  = lit_reg;
        ram_re     = 1'b0;
        res        = '0;
        clear      = 1'b0;
        emit_now   = 1'b0;
        issue      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_last;
                    if (err_reg)
                    begin
                        clear = in_last;
                    end
                    else if (bits_reg == '0)
                    begin
                        flag_next = in_byte;
                        bits_next = FLAG_COUNT;
                        if (in_last)
                        begin
                            state_next = ST_END;
                        end
                    end
                    else if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        flag_next = {flag_reg[BYTE_W-2:0], 1'b0};
                        bits_next = bits_reg - BITS_W'(1);
                        if (prod_reg < COUNT_BITS'(ref_dist))
                        begin
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            state_next = ST_COPY;
                            src_next   = wp_reg - ADDR_W'(ref_dist);
                            left_next  = len;
                            rdp_next   = 1'b0;
                            fwd_next   = 1'b0;
                        end
                    end
                    else if (flag_reg[BYTE_W-1])
                    begin
                        high_next = in_byte;
                        pend_next = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_END;
                        end
                    end
                    else
                    begin
                        flag_next  = {flag_reg[BYTE_W-2:0], 1'b0};
                        bits_next  = bits_reg - BITS_W'(1);
                        lit_next   = in_byte;
                        state_next = ST_LIT;
                    end
                end
            end

            ST_LIT:
            begin
                if (can_emit)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = lit_reg;
                    wp_next      = wp_reg + ADDR_W'(1);
                    prod_next    = prod_inc;
                    res.valid    = 1'b1;
                    res.kind     = KIND_BYTE;
                    res.data     = lit_reg;
                    res.total    = TOTAL_W'(prod_inc);
                    res.run_last = !last_reg;
                    state_next   = last_reg ? ST_END : ST_IDLE;
                end
            end

            ST_COPY:
            begin
                emit_now = rdp_reg && can_emit;
                issue    = (left_reg != '0) && (!rdp_reg || emit_now);
                if (emit_now)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = copy_byte;
                    wp_next      = wp_reg + ADDR_W'(1);
                    prod_next    = prod_inc;
                    res.valid    = 1'b1;
                    res.kind     = KIND_BYTE;
                    res.data     = copy_byte;
                    res.total    = TOTAL_W'(prod_inc);
                    res.run_last = (left_reg == '0) && !last_reg;
                    if (left_reg == '0)
                    begin
                        state_next = last_reg ? ST_END : ST_IDLE;
                    end
                end
                if (issue)
                begin
                    ram_re    = 1'b1;
                    src_next  = src_reg + ADDR_W'(1);
                    left_next = left_reg - LEN_W'(1);
                    // forward a byte written to the entry read in the same cycle
                    fwd_next  = emit_now && (src_reg == wp_reg);
                    fwdd_next = copy_byte;
                end
                rdp_next = issue || (rdp_reg && !emit_now);
            end

            ST_ERR:
            begin
                if (can_emit)
                begin
                    res.valid    = 1'b1;
                    res.kind     = KIND_ERR;
                    res.total    = TOTAL_W'(prod_reg);
                    res.run_last = 1'b1;
                    err_next     = 1'b1;
                    clear        = last_reg;
                    state_next   = ST_IDLE;
                end
            end

            ST_END:
            begin
                if (can_emit)
                begin
                    res.valid    = 1'b1;
                    res.kind     = KIND_END;
                    res.total    = TOTAL_W'(prod_reg);
                    res.run_last = 1'b1;
                    clear        = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear)
        begin
            wp_next   = '0;
            prod_next = '0;
            flag_next = '0;
            bits_next = '0;
            pend_next = 1'b0;
            high_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            prod_reg  <= '0;
            flag_reg  <= '0;
            bits_reg  <= '0;
            pend_reg  <= 1'b0;
            high_reg  <= '0;
            err_reg   <= 1'b0;
            last_reg  <= 1'b0;
            src_reg   <= '0;
            left_reg  <= '0;
            rdp_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            prod_reg  <= prod_next;
            flag_reg  <= flag_next;
            bits_reg  <= bits_next;
            pend_reg  <= pend_next;
            high_reg  <= high_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
            src_reg   <= src_next;
            left_reg  <= left_next;
            rdp_reg   <= rdp_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg  <= lit_next;
        fwdd_reg <= fwdd_next;
    end

endmodule

// ===== rtl/core/lz77_flag_byte_decompressor.sv =====
// LZ77 flag-byte decompressor, top level: token engine plus output register.
// A literal result passes the state and output registers; a copy's first byte also passes
// the RAM read register. Flag and pair-first bytes: one per cycle. A literal or reference
// holds input until emitted; a copy reads one history byte a cycle while output accepts.
// Reset: asynchronous, clears the control state; the history RAM is not cleared.
// Depends on lzfb_pkg, lzfb_if and lzfb_engine.
module lz77_flag_byte_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    lzfb_in_if.sink    in_ch,
    lzfb_out_if.source out_ch
);
    import lzfb_pkg::*;

    result_t            res;
    logic               can_emit;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               rlast_reg;

    assign can_emit = !out_valid_reg || out_ch.ready;

    lzfb_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_byte  (in_ch.in_byte),
        .in_last  (in_ch.in_last),
        .in_ready (in_ch.ready),
        .can_emit (can_emit),
        .res      (res)
    );

    assign out_valid_next = res.valid || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            kind_reg  <= res.kind;
            byte_reg  <= res.data;
            total_reg <= res.total;
            rlast_reg <= res.run_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_kind = kind_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.total_count = total_reg;
    assign out_ch.run_last    = rlast_reg;

endmodule

// ===== rtl/core/lzfb_checker.sv =====
// Port-level checker for the LZ77 flag-byte decompressor, bound to the top level.
// Depends on lzfb_pkg and the top level's channel interfaces.
module lzfb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   result_kind,
    input logic [lzfb_pkg::BYTE_W-1:0]  out_byte,
    input logic [lzfb_pkg::TOTAL_W-1:0] total_count,
    input logic                         run_last
);
    import lzfb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(out_byte) && $stable(total_count) && $stable(run_last))
        else $error("stalled output transaction changed");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == KIND_BYTE || result_kind == KIND_END
            || result_kind == KIND_ERR)
        else $error("illegal result kind");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_BYTE |-> run_last && out_byte == '0)
        else $error("end or error transaction without run_last or with data");

    a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BYTE |-> total_count != '0)
        else $error("byte transaction with zero count");

endmodule

bind lz77_flag_byte_decompressor lzfb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .result_kind (out_ch.result_kind),
    .out_byte    (out_ch.out_byte),
    .total_count (out_ch.total_count),
    .run_last    (out_ch.run_last)
);
